// ===== rtl/bresenham_line_stepper_core_assert.svh =====
// ============================================================================
// Assertion macros for the line stepper
// Shared property forms used by the checker.
// ============================================================================
`ifndef BRESENHAM_LINE_STEPPER_CORE_ASSERT_SVH
`define BRESENHAM_LINE_STEPPER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BLS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line stepper assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line stepper assertion failed");

`endif

// ===== rtl/bls_pkg.sv =====
// ============================================================================
// Line stepper package
// Shared constants and types for the line stepper front end, queue and back end.
// ============================================================================
package bls_pkg;

   // Default coordinate width.
   localparam int DEF_COORD_BITS = 12;

   // Depth of the queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 4;

   // Item action codes.
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   // Control flags carried with each queued item.
   typedef struct packed {
      logic is_step;
      logic y_major;
      logic minor_down;
      logic busy;
   } entry_ctrl_type;

endpackage

// ===== rtl/bls_front.sv =====
// ============================================================================
// Line stepper front end
// Accepts request beats, measures the endpoint deltas and builds the line
// setup (start point, end coordinate, error terms) for the back end.
// ============================================================================
module bls_front #(
   parameter int COORD_BITS = bls_pkg::DEF_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [COORD_BITS-1:0]         req_start_x,
   input  logic [COORD_BITS-1:0]         req_start_y,
   input  logic [COORD_BITS-1:0]         req_end_x,
   input  logic [COORD_BITS-1:0]         req_end_y,
   output logic                          push_valid,
   input  logic                          push_ready,
   output bls_pkg::entry_ctrl_type       push_ctrl,
   output logic [COORD_BITS-1:0]         push_x,
   output logic [COORD_BITS-1:0]         push_y,
   output logic [COORD_BITS-1:0]         push_end,
   output logic signed [COORD_BITS+2:0]  push_err,
   output logic [COORD_BITS+1:0]         push_hold,
   output logic signed [COORD_BITS+2:0]  push_move
);

   localparam int W = COORD_BITS;

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_step_ff;
   logic [W-1:0]  x0_ff, y0_ff, x1_ff, y1_ff;
   logic [W-1:0]  adx_ff, ady_ff, adx_in, ady_in;
   logic          dxneg_ff, dyneg_ff, x_ge, y_ge;
   logic          s1_ready, load;
   logic          zero_len, y_major, from_end;
   logic [W-1:0]  dmaj, dmin;

   // The stage moves on when it is empty or its beat goes into the queue.
   assign s1_ready   = !s1_valid_ff || push_ready;
   assign req_ready  = s1_ready;
   assign load       = req_valid && s1_ready;
   assign push_valid = s1_valid_ff;

   // Absolute deltas, each as a compare and two parallel subtractions.
   always_comb begin
      x_ge   = (req_end_x >= req_start_x);
      y_ge   = (req_end_y >= req_start_y);
      adx_in = x_ge ? (req_end_x - req_start_x) : (req_start_x - req_end_x);
      ady_in = y_ge ? (req_end_y - req_start_y) : (req_start_y - req_end_y);
   end

   always_comb begin
      s1_valid_in = load ? 1'b1 : (push_ready ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_step_ff <= (req_action == bls_pkg::ACT_STEP);
         x0_ff      <= req_start_x;
         y0_ff      <= req_start_y;
         x1_ff      <= req_end_x;
         y1_ff      <= req_end_y;
         adx_ff     <= adx_in;
         ady_ff     <= ady_in;
         dxneg_ff   <= !x_ge;
         dyneg_ff   <= !y_ge;
      end
   end

   // Axis choice, walking direction and initial error terms.
   always_comb begin
      zero_len = (adx_ff == '0) && (ady_ff == '0);
      y_major  = (ady_ff >= adx_ff) && !zero_len;
      dmaj     = y_major ? ady_ff : adx_ff;
      dmin     = y_major ? adx_ff : ady_ff;
      from_end = y_major ? dyneg_ff : dxneg_ff;

      push_ctrl.is_step    = s1_step_ff;
      push_ctrl.y_major    = y_major;
      push_ctrl.minor_down = dxneg_ff ^ dyneg_ff;
      push_ctrl.busy       = (dmaj != '0);

      push_x   = from_end ? x1_ff : x0_ff;
      push_y   = from_end ? y1_ff : y0_ff;
      if (y_major) begin
         push_end = from_end ? y0_ff : y1_ff;
      end else begin
         push_end = from_end ? x0_ff : x1_ff;
      end
      push_err  = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
      push_hold = {1'b0, dmin, 1'b0};
      push_move = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
   end

endmodule

// ===== rtl/bls_queue.sv =====
// ============================================================================
// Line stepper queue
// Small register queue that decouples the front end from the back end.
// ============================================================================
module bls_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = bls_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output logic [DATA_BITS-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] store_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/bls_back.sv =====
// ============================================================================
// Line stepper back end
// Holds the line state, walks one pixel per step beat and registers the
// response beat.
// ============================================================================
module bls_back #(
   parameter int COORD_BITS = bls_pkg::DEF_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  bls_pkg::entry_ctrl_type       pop_ctrl,
   input  logic [COORD_BITS-1:0]         pop_x,
   input  logic [COORD_BITS-1:0]         pop_y,
   input  logic [COORD_BITS-1:0]         pop_end,
   input  logic signed [COORD_BITS+2:0]  pop_err,
   input  logic [COORD_BITS+1:0]         pop_hold,
   input  logic signed [COORD_BITS+2:0]  pop_move,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [COORD_BITS-1:0]         rsp_pixel_x,
   output logic [COORD_BITS-1:0]         rsp_pixel_y,
   output logic                          rsp_valid_res,
   output logic                          rsp_last
);

   localparam int W = COORD_BITS;

   // Line state.
   logic [W-1:0]          cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [W-1:0]          major_end_ff, major_end_in;
   logic signed [W+2:0]   err_ff, err_in;
   logic [W+1:0]          hold_ff, hold_in;
   logic signed [W+2:0]   move_ff, move_in;
   logic                  y_major_ff, y_major_in, down_ff, down_in;
   logic                  busy_ff, busy_in;

   // Response register.
   logic                  out_valid_ff;
   logic [W-1:0]          out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                  out_res_ff, out_res_in, out_last_ff, out_last_in;

   logic                  fire;
   logic [W-1:0]          maj, mnr, maj_nx, mnr_nx;
   logic                  is_last;

   assign pop_ready     = !out_valid_ff || rsp_ready;
   assign fire          = pop_valid && pop_ready;
   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_x   = out_x_ff;
   assign rsp_pixel_y   = out_y_ff;
   assign rsp_valid_res = out_res_ff;
   assign rsp_last      = out_last_ff;

   // Next state and response for the beat at the queue head.
   always_comb begin
      maj     = y_major_ff ? cur_y_ff : cur_x_ff;
      mnr     = y_major_ff ? cur_x_ff : cur_y_ff;
      maj_nx  = maj + 1'b1;
      mnr_nx  = err_ff[W+2] ? mnr : (down_ff ? mnr - 1'b1 : mnr + 1'b1);
      is_last = (maj_nx == major_end_ff);

      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      major_end_in = major_end_ff;
      err_in       = err_ff;
      hold_in      = hold_ff;
      move_in      = move_ff;
      y_major_in   = y_major_ff;
      down_in      = down_ff;
      busy_in      = busy_ff;
      out_x_in     = '0;
      out_y_in     = '0;
      out_res_in   = 1'b0;
      out_last_in  = 1'b0;

      if (!pop_ctrl.is_step) begin
         // New line: load the setup and show its first pixel.
         cur_x_in     = pop_x;
         cur_y_in     = pop_y;
         major_end_in = pop_end;
         err_in       = pop_err;
         hold_in      = pop_hold;
         move_in      = pop_move;
         y_major_in   = pop_ctrl.y_major;
         down_in      = pop_ctrl.minor_down;
         busy_in      = pop_ctrl.busy;
         out_x_in     = pop_x;
         out_y_in     = pop_y;
         out_res_in   = 1'b1;
         out_last_in  = !pop_ctrl.busy;
      end else if (busy_ff) begin
         // One step along the major axis, minor axis when the error allows.
         cur_x_in    = y_major_ff ? mnr_nx : maj_nx;
         cur_y_in    = y_major_ff ? maj_nx : mnr_nx;
         err_in      = err_ff[W+2] ? err_ff + $signed({1'b0, hold_ff}) : err_ff + move_ff;
         busy_in     = !is_last;
         out_x_in    = cur_x_in;
         out_y_in    = cur_y_in;
         out_res_in  = 1'b1;
         out_last_in = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         major_end_ff <= '0;
         err_ff       <= '0;
         hold_ff      <= '0;
         move_ff      <= '0;
         y_major_ff   <= 1'b0;
         down_ff      <= 1'b0;
         busy_ff      <= 1'b0;
      end else if (fire) begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         major_end_ff <= major_end_in;
         err_ff       <= err_in;
         hold_ff      <= hold_in;
         move_ff      <= move_in;
         y_major_ff   <= y_major_in;
         down_ff      <= down_in;
         busy_ff      <= busy_in;
      end
   end

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pop_ready) begin
         out_valid_ff <= pop_valid;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (fire) begin
         out_x_ff    <= out_x_in;
         out_y_ff    <= out_y_in;
         out_res_ff  <= out_res_in;
         out_last_ff <= out_last_in;
      end
   end

endmodule

// ===== rtl/bresenham_line_stepper_core.sv =====
// ============================================================================
// Bresenham line stepper core
// Line rasterizer: a start beat sets up a line, each step beat yields a pixel.
// ============================================================================
// Usage:
//   Request channel (req_*): a start beat (action start) carries both endpoints
//   and returns the first pixel; a step beat returns the next pixel, with
//   rsp_last high on the final pixel. A step while no line is active returns
//   a beat with rsp_valid_res low and zero fields. A start during a line
//   abandons it.
//   Response channel (rsp_*): exactly one beat per request beat, in order.
//   A beat loads the front-end register when accepted, then a queue entry,
//   then the back-end response register; a stall can hold it in any of them.
//   Throughput is one beat per cycle while rsp_ready stays high; each step
//   adds to the error term and compares the next major coordinate to its end.
//   A 4-entry queue separates front and back end, so requests keep flowing
//   while a response waits; under a sustained stall req_ready drops once the
//   queue and the front register are full, and no beat is lost.
//   Reset (synchronous, active high) empties the pipeline and leaves it idle.
// ============================================================================
module bresenham_line_stepper_core #(
   parameter int COORD_BITS = bls_pkg::DEF_COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic                  rsp_valid_res,
   output logic                  rsp_last
);

   localparam int W         = COORD_BITS;
   localparam int CTRL_BITS = $bits(bls_pkg::entry_ctrl_type);
   localparam int DATA_BITS = 6 * W + 8 + CTRL_BITS;

   logic                     push_valid, push_ready, pop_valid, pop_ready;
   bls_pkg::entry_ctrl_type  push_ctrl, pop_ctrl;
   logic [W-1:0]             push_x, push_y, push_end, pop_x, pop_y, pop_end;
   logic signed [W+2:0]      push_err, push_move, pop_err, pop_move;
   logic [W+1:0]             push_hold, pop_hold;
   logic [DATA_BITS-1:0]     push_data, pop_data;

   // Front end: delta measurement and line setup.
   bls_front #(.COORD_BITS(W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_ctrl   (push_ctrl),
      .push_x      (push_x),
      .push_y      (push_y),
      .push_end    (push_end),
      .push_err    (push_err),
      .push_hold   (push_hold),
      .push_move   (push_move)
   );

   // Queue entry packing.
   assign push_data = {push_ctrl, push_x, push_y, push_end, push_err, push_hold, push_move};
   assign {pop_ctrl, pop_x, pop_y, pop_end, pop_err, pop_hold, pop_move} = pop_data;

   bls_queue #(
      .DATA_BITS (DATA_BITS),
      .DEPTH     (bls_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back end: line walking and response register.
   bls_back #(.COORD_BITS(W)) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_ctrl      (pop_ctrl),
      .pop_x         (pop_x),
      .pop_y         (pop_y),
      .pop_end       (pop_end),
      .pop_err       (pop_err),
      .pop_hold      (pop_hold),
      .pop_move      (pop_move),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_valid_res (rsp_valid_res),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== rtl/bls_checker.sv =====
// ============================================================================
// Line stepper port checker
// Watches the top-level ports of the line stepper over time.
// ============================================================================
`include "bresenham_line_stepper_core_assert.svh"

module bls_checker #(
   parameter int COORD_BITS = bls_pkg::DEF_COORD_BITS
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS-1:0] rsp_pixel_x,
   input logic [COORD_BITS-1:0] rsp_pixel_y,
   input logic                  rsp_valid_res,
   input logic                  rsp_last
);

   logic [2*COORD_BITS+1:0] rsp_payload;
   logic                    rsp_stall;
   logic                    idle_beat;
   logic                    idle_zero;

   assign rsp_payload = {rsp_pixel_x, rsp_pixel_y, rsp_valid_res, rsp_last};
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign idle_beat   = rsp_valid && !rsp_valid_res;
   assign idle_zero   = !rsp_last && (rsp_pixel_x == '0) && (rsp_pixel_y == '0);

   // A stalled response beat holds its place and its payload.
   `BLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // A step without an active line carries an all-zero payload.
   `BLS_ASSERT_NOW(a_idle_zero, clock, reset, idle_beat, idle_zero)

   // No response beat is shown right after reset.
   `BLS_ASSERT_NOW(a_reset_empty, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind bresenham_line_stepper_core bls_checker #(.COORD_BITS(COORD_BITS)) u_bls_checker (.*);
